@@ hdl/ebc_pkg.sv @@
// shared types and constants for the eight-bit banked core
// no dependencies
`default_nettype none
package ebc_pkg;
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0, CMD_READ = 2'd1, CMD_EXEC = 2'd2, CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_DECODE, ST_LIT, ST_DATA, ST_DONE
    } t_state;

    localparam logic [7:0] SAVE_SLOT = 8'hC4;

    typedef struct packed {
        logic        in_beat;
        logic        mem_cmd;
        logic        fetch_ins;
        logic        fetch_lit;
        logic        do_data;
        logic        do_exec;
    } t_ctrl;

    typedef struct packed {
        logic        halted;
        logic        need_lit;
        logic        need_data;
    } t_stat;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] mem_address;
        logic [7:0]  mem_write_data;
        logic [7:0]  parallel_in;
        logic        serial_in_bit;
    } t_in;

    typedef struct packed {
        logic [7:0]  mem_read_data;
        logic        halted;
        logic [7:0]  par_out_value;
        logic        parallel_ready;
        logic        serial_clock_out;
        logic        serial_out_bit;
        logic [7:0]  device_enable;
        logic [7:0]  accum_a_out;
        logic [7:0]  accum_b_out;
        logic [7:0]  result_out;
        logic [15:0] program_counter;
    } t_out;
endpackage
`default_nettype wire

@@ hdl/ebc_if.sv @@
// valid/ready channel interfaces for command and result beats
// depends on ebc_pkg
`default_nettype none
interface ebc_in_if;
    logic         valid;
    logic         ready;
    ebc_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ebc_out_if;
    logic          valid;
    logic          ready;
    ebc_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/ebc_ctrl.sv @@
// sequencer: fetch, optional literal fetch, optional data access, result
// depends on ebc_pkg
`default_nettype none
module ebc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [1:0]     i_command,
    input  wire ebc_pkg::t_stat i_stat,
    input  wire logic           i_out_busy,
    output ebc_pkg::t_ctrl      o_ctrl,
    output logic               o_ready,
    output logic               o_done
);
    ebc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ebc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ebc_pkg::ST_IDLE: begin
                if (i_valid && !i_out_busy) begin
                    if (i_command == ebc_pkg::CMD_EXEC && !i_stat.halted)
                        n_state = ebc_pkg::ST_FETCH;
                    else
                        n_state = ebc_pkg::ST_DONE;
                end
            end
            ebc_pkg::ST_FETCH:  n_state = ebc_pkg::ST_DECODE;
            ebc_pkg::ST_DECODE: begin
                if (i_stat.need_lit)       n_state = ebc_pkg::ST_LIT;
                else if (i_stat.need_data) n_state = ebc_pkg::ST_DATA;
                else                       n_state = ebc_pkg::ST_DONE;
            end
            ebc_pkg::ST_LIT:  n_state = ebc_pkg::ST_DATA;
            ebc_pkg::ST_DATA: n_state = ebc_pkg::ST_DONE;
            ebc_pkg::ST_DONE: n_state = ebc_pkg::ST_IDLE;
            default:          n_state = ebc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_ready = 1'b0;
        o_done = 1'b0;
        case (r_state)
            ebc_pkg::ST_IDLE: begin
                o_ready = !i_out_busy;
                o_ctrl.in_beat = i_valid && !i_out_busy;
                o_ctrl.mem_cmd = i_valid && !i_out_busy;
            end
            ebc_pkg::ST_FETCH:  o_ctrl.fetch_ins = 1'b1;
            ebc_pkg::ST_DECODE: o_ctrl.do_exec = !i_stat.need_lit && !i_stat.need_data;
            ebc_pkg::ST_LIT:    o_ctrl.fetch_lit = 1'b1;
            ebc_pkg::ST_DATA:   o_ctrl.do_data = 1'b1;
            ebc_pkg::ST_DONE:   o_done = 1'b1;
            default:            o_done = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

@@ hdl/ebc_datapath.sv @@
// registers, memory and instruction execution of the core
// depends on ebc_pkg
`default_nettype none
module ebc_datapath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ebc_pkg::t_ctrl i_ctrl,
    input  wire ebc_pkg::t_in   i_in,
    output ebc_pkg::t_stat      o_stat,
    output ebc_pkg::t_out       o_out
);
    logic [7:0] r_mem [65536];
    logic [7:0] r_rdata;
    logic [15:0] n_raddr;
    logic        n_we;
    logic [15:0] n_waddr;
    logic [7:0]  n_wdata;

    ebc_pkg::t_in r_in;
    logic [7:0] r_ins, r_lit;
    logic       r_cmd_read;
    logic [7:0] w_mrd;

    logic [7:0]  r_pcp, r_pco, r_h, r_g, r_l, r_a, r_b, r_prev, r_res, r_ofs, r_loop;
    logic [7:0]  r_sin, r_sout, r_pout, r_en;
    logic [15:0] r_mp;
    logic        r_sclk, r_rdy, r_halt, r_sbit;
    logic [7:0]  n_pcp, n_pco, n_h, n_g, n_l, n_a, n_b, n_prev, n_res, n_ofs, n_loop;
    logic [7:0]  n_sin, n_sout, n_pout, n_en;
    logic [15:0] n_mp;
    logic        n_sclk, n_rdy, n_halt, n_sbit;

    logic [7:0] w_sum, w_src, w_alu, w_fpage, w_gp_offs;
    logic [2:0] w_srcsel;
    logic [3:0] w_lo;
    logic [1:0] w_guide;
    logic       w_move, w_gp, w_kick;
    logic [15:0] w_gp_addr, w_slot_rd, w_slot_wr;

    function automatic logic [15:0] f_daddr(input logic [7:0] offs, input logic [7:0] h,
                                            input logic [7:0] g, input logic [7:0] l);
        logic [7:0] pg;
        if (!offs[7])      pg = h;
        else if (!offs[6]) pg = g;
        else               pg = l;
        return {pg, offs};
    endfunction

    assign w_sum    = r_res + r_ofs;
    assign w_lo     = r_ins[3:0];
    assign w_srcsel = r_ins[6:4];
    assign w_move   = r_ins[7];
    assign w_gp     = !r_ins[7] && !r_ins[6];
    assign w_guide  = r_ins[5:4];
    assign w_kick   = w_gp && (w_guide == 2'd0);
    assign w_gp_offs = r_ins[2] ? {6'b110000, r_ins[1:0]} : {6'b100000, r_ins[1:0]};
    assign w_gp_addr = {r_ins[2] ? r_l : r_g, w_gp_offs};
    assign w_slot_rd = {r_l, ebc_pkg::SAVE_SLOT};
    assign w_slot_wr = {r_l - 8'd1, ebc_pkg::SAVE_SLOT};
    assign w_fpage   = !r_pco[7] ? r_pcp : (!r_pco[6] ? r_g : r_l);

    // literal needed for a source-0 move that is not the return form
    assign o_stat.need_lit  = w_move && w_srcsel == 3'd0 && w_lo != 4'd1;
    assign o_stat.need_data = (w_move && (w_srcsel == 3'd1 && w_lo != 4'd1 || w_lo == 4'd1))
                            || (w_gp && !w_kick) || (w_kick && (w_lo == 4'd6 || w_lo == 4'd7));
    assign o_stat.halted    = r_halt;

    always_comb begin
        case (w_lo)
            4'd0: w_alu = r_a;
            4'd1: w_alu = r_b;
            4'd2: w_alu = ~r_a;
            4'd3: w_alu = ~r_b;
            4'd4: w_alu = {r_a[6:0], 1'b0};
            4'd5: w_alu = {r_b[6:0], 1'b0};
            4'd6: w_alu = {1'b0, r_a[7:1]};
            4'd7: w_alu = {1'b0, r_b[7:1]};
            4'd8: w_alu = r_a & r_b;
            4'd9: w_alu = r_a | r_b;
            4'd10: w_alu = r_a ^ r_b;
            4'd11: w_alu = r_a + r_b;
            4'd12: w_alu = {7'd0, ({1'b0, r_a} + {1'b0, r_b}) > 9'd255};
            4'd13: w_alu = (r_a < r_b) ? 8'hFF : 8'h00;
            4'd14: w_alu = (r_a == r_b) ? 8'hFF : 8'h00;
            default: w_alu = (r_a > r_b) ? 8'hFF : 8'h00;
        endcase
    end

    always_comb begin
        case (w_srcsel)
            3'd0: w_src = r_lit;
            3'd1: w_src = r_rdata;
            3'd2: w_src = w_sum;
            3'd3: w_src = r_h;
            3'd4: w_src = r_g;
            3'd5: w_src = r_l;
            3'd6: w_src = r_sin;
            default: w_src = r_in.parallel_in;
        endcase
    end

    // memory address and write for each step
    always_comb begin
        n_raddr = {w_fpage, r_pco};
        n_we = 1'b0;
        n_waddr = i_in.mem_address;
        n_wdata = i_in.mem_write_data;
        if (i_ctrl.mem_cmd) begin
            n_raddr = i_in.mem_address;
            n_we = i_in.command == ebc_pkg::CMD_WRITE;
        end else if (i_ctrl.fetch_ins || i_ctrl.fetch_lit) begin
            n_raddr = {w_fpage, r_pco};
        end else if (i_ctrl.do_data) begin
            // store-type accesses of the data step
            if (w_move) begin
                n_waddr = r_mp;
                n_wdata = w_src;
                n_we = w_lo == 4'd1 && w_srcsel != 3'd1 && w_srcsel != 3'd0;
            end else if (w_kick) begin
                n_waddr = w_slot_wr;
                n_wdata = w_sum;
                n_we = w_lo == 4'd7;
            end else begin
                n_waddr = w_gp_addr;
                n_wdata = (w_guide == 2'd1) ? r_a : ((w_guide == 2'd2) ? r_b : w_sum);
                n_we = r_ins[3];
            end
        end
        // prefetch the data operand while decoding
        if (!i_ctrl.mem_cmd && !i_ctrl.fetch_ins && !i_ctrl.fetch_lit && !i_ctrl.do_data) begin
            if (w_move)      n_raddr = r_mp;
            else if (w_kick) n_raddr = w_slot_rd;
            else             n_raddr = w_gp_addr;
        end
        if (i_ctrl.fetch_lit) n_raddr = r_mp;
    end

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        r_rdata <= r_mem[n_raddr];
    end

    always_comb begin
        n_pcp = r_pcp; n_pco = r_pco; n_h = r_h; n_g = r_g; n_l = r_l;
        n_a = r_a; n_b = r_b; n_prev = r_prev; n_res = r_res; n_ofs = r_ofs;
        n_loop = r_loop; n_sin = r_sin; n_sout = r_sout; n_pout = r_pout; n_en = r_en;
        n_mp = r_mp; n_sclk = r_sclk; n_rdy = r_rdy; n_halt = r_halt; n_sbit = r_sbit;
        if (i_ctrl.in_beat && i_in.command == ebc_pkg::CMD_RESTART) begin
            n_halt = 1'b0; n_rdy = 1'b0; n_pcp = 8'd0; n_pco = 8'd0;
        end
        if (i_ctrl.fetch_ins || i_ctrl.fetch_lit) n_pco = r_pco + 8'd1;
        if (i_ctrl.do_exec || i_ctrl.do_data) begin
            if (w_move) begin
                if (w_srcsel == 3'd0 && w_lo == 4'd1) begin
                    n_pco = w_sum; n_pcp = r_h;
                end else if (w_srcsel == 3'd1 && w_lo == 4'd1) begin
                    n_pcp = r_pcp + 8'd1; n_pco = 8'd0; n_h = r_pcp + 8'd1;
                end else begin
                    case (w_lo)
                        4'd0: n_loop = w_src;
                        4'd1: n_loop = r_loop;
                        4'd2: begin n_res = w_src; n_ofs = 8'd0; end
                        4'd3: n_h = w_src;
                        4'd4: n_g = w_src;
                        4'd5: n_l = w_src;
                        4'd6: n_sout = w_src;
                        4'd7: begin n_pout = w_src; n_rdy = 1'b1; n_halt = 1'b1; end
                        4'd8: n_en = w_src;
                        4'd9: n_pco = w_src;
                        4'd10: begin
                            n_loop = r_loop - 8'd1;
                            if (r_loop != 8'd1) n_pco = w_src;
                        end
                        4'd11: if (w_sum != 8'd0) n_pco = w_src;
                        4'd12: if (w_sum == 8'd0) n_pco = w_src;
                        4'd13: begin
                            n_res = r_pco; n_ofs = 8'd0; n_pco = 8'd0;
                            n_h = r_pcp; n_pcp = {3'd0, w_src[4:0]};
                        end
                        4'd14: begin
                            n_prev = r_b; n_b = w_src; n_mp = f_daddr(w_src, r_h, r_g, r_l);
                        end
                        default: begin
                            n_prev = r_a; n_a = w_src; n_mp = f_daddr(w_src, r_h, r_g, r_l);
                        end
                    endcase
                end
            end else if (w_kick) begin
                case (w_lo)
                    4'd0: n_halt = 1'b1;
                    4'd1: n_sin = {r_sin[6:0], r_in.serial_in_bit};
                    4'd2: begin n_sbit = r_sout[7]; n_sout = {r_sout[6:0], 1'b0}; end
                    4'd3: n_sclk = 1'b0;
                    4'd4: n_sclk = 1'b1;
                    4'd5: n_rdy = 1'b0;
                    4'd6: begin n_res = r_rdata; n_ofs = 8'd0; n_l = r_l + 8'd1; end
                    4'd7: n_l = r_l - 8'd1;
                    4'd8: n_a = r_prev;
                    4'd9: n_b = r_prev;
                    default: n_loop = r_loop;
                endcase
            end else if (w_gp) begin
                if (w_guide == 2'd1) n_prev = r_a;
                else if (w_guide == 2'd2) n_prev = r_b;
                if (!r_ins[3]) begin
                    if (w_guide == 2'd1) begin
                        n_a = r_rdata; n_mp = f_daddr(r_rdata, r_h, r_g, r_l);
                    end else if (w_guide == 2'd2) begin
                        n_b = r_rdata; n_mp = f_daddr(r_rdata, r_h, r_g, r_l);
                    end else begin
                        n_res = r_rdata; n_ofs = 8'd0;
                    end
                end
            end else if (!r_ins[5]) begin
                n_res = r_pco; n_ofs = 8'd0; n_pco = 8'd0;
                n_h = r_pcp; n_pcp = {3'd0, r_ins[4:0]};
            end else if (r_ins[4]) begin
                n_res = w_alu; n_ofs = 8'd0;
            end else begin
                n_ofs = r_ins[3] ? {4'hF, r_ins[3:0]} : {4'd0, r_ins[3:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcp <= '0; r_pco <= '0; r_h <= '0; r_g <= '0; r_l <= '0;
            r_a <= '0; r_b <= '0; r_prev <= '0; r_res <= '0; r_ofs <= '0; r_loop <= '0;
            r_sin <= '0; r_sout <= '0; r_pout <= '0; r_en <= '0; r_mp <= '0;
            r_sclk <= 1'b0; r_rdy <= 1'b0; r_halt <= 1'b0; r_sbit <= 1'b0;
            r_cmd_read <= 1'b0;
        end else begin
            r_pcp <= n_pcp; r_pco <= n_pco; r_h <= n_h; r_g <= n_g; r_l <= n_l;
            r_a <= n_a; r_b <= n_b; r_prev <= n_prev; r_res <= n_res; r_ofs <= n_ofs;
            r_loop <= n_loop; r_sin <= n_sin; r_sout <= n_sout; r_pout <= n_pout;
            r_en <= n_en; r_mp <= n_mp; r_sclk <= n_sclk; r_rdy <= n_rdy;
            r_halt <= n_halt; r_sbit <= n_sbit;
            if (i_ctrl.in_beat) r_cmd_read <= i_in.command == ebc_pkg::CMD_READ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.in_beat) r_in <= i_in;
        if (i_ctrl.fetch_ins) r_ins <= r_mem[n_raddr];
        if (i_ctrl.fetch_lit) r_lit <= r_mem[{w_fpage, r_pco}];
    end

    assign w_mrd = r_cmd_read ? r_rdata : 8'd0;

    assign o_out.mem_read_data    = w_mrd;
    assign o_out.halted           = r_halt;
    assign o_out.par_out_value    = r_pout;
    assign o_out.parallel_ready   = r_rdy;
    assign o_out.serial_clock_out = r_sclk;
    assign o_out.serial_out_bit   = r_sbit;
    assign o_out.device_enable    = r_en;
    assign o_out.accum_a_out      = r_a;
    assign o_out.accum_b_out      = r_b;
    assign o_out.result_out       = w_sum;
    assign o_out.program_counter  = {r_pcp, r_pco};
endmodule
`default_nettype wire

@@ hdl/eight_bit_banked_cpu_core.sv @@
// eight-bit banked cpu core: a command beat in gives one status beat out.
// A memory command, a restart or an execute while halted goes from idle
// straight to done; an executed instruction passes fetch, decode, an optional
// literal fetch, an optional data step and done, all on the one 64 KiB memory.
// A new command is taken only in idle while no status beat waits. The memory
// has no reset; unwritten bytes read as undefined.
// depends on ebc_pkg, ebc_if, ebc_ctrl, ebc_datapath
`default_nettype none
module eight_bit_banked_cpu_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ebc_in_if.sink    i_cmd,
    ebc_out_if.source o_res
);
    ebc_pkg::t_ctrl w_ctrl;
    ebc_pkg::t_stat w_stat;
    ebc_pkg::t_out  w_out;
    logic           w_done;
    logic           r_valid;
    ebc_pkg::t_out  r_data;

    ebc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_cmd.valid),
        .i_command  (i_cmd.data.command),
        .i_stat     (w_stat),
        .i_out_busy (r_valid),
        .o_ctrl     (w_ctrl),
        .o_ready    (i_cmd.ready),
        .o_done     (w_done)
    );

    ebc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_in    (i_cmd.data),
        .o_stat  (w_stat),
        .o_out   (w_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_done) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) r_data <= w_out;
    end

    assign o_res.valid = r_valid;
    assign o_res.data  = r_data;
endmodule
`default_nettype wire
